>>> hw/rtl/mep_pkg.sv
// package for the mandelbrot escape pixel block
// shared widths, constants, register codes, types and the saturation helper
// no dependencies
package mep_pkg;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 28;
	localparam int PIX_W      = 12;
	localparam int DIM_W      = 13;
	localparam int CNT_W      = 16;
	localparam int COLOR_W    = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	// shared multiplier: one guard bit so a span of two borders fits
	localparam int MUL_W  = COORD_BITS + 1;
	localparam int PROD_W = 2 * MUL_W;
	// square terms after the floor shift, cross term after the shift by one less
	localparam int SQ_W    = PROD_W - FRAC_BITS;
	localparam int CROSS_W = PROD_W - FRAC_BITS + 1;
	// working width ahead of saturation
	localparam int SAT_W = 48;

	// shared divider: mapping products are below 2^44 in magnitude
	localparam int DVD_W     = 44;
	localparam int DVS_W     = 16;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);

	localparam logic signed [SQ_W:0] ESCAPE_LIMIT = (SQ_W + 1)'(64'd4 << FRAC_BITS);
	localparam logic [COLOR_W-1:0] COLOR_FULL   = 16'hffff;
	localparam logic [COLOR_W-1:0] COLOR_NONE   = 16'h0000;
	localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 16'hffff;

	localparam logic [DIM_W-1:0]      RST_IMAGE_WIDTH  = 13'd800;
	localparam logic [DIM_W-1:0]      RST_IMAGE_HEIGHT = 13'd650;
	localparam logic [CNT_W-1:0]      RST_ITER_LIMIT   = 16'd100;
	localparam logic [CFG_DATA_W-1:0] RST_RE_MIN       = 32'hE000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_RE_MAX       = 32'h1000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_IM_MIN       = 32'hECCC_CCCD;
	localparam logic [CFG_DATA_W-1:0] RST_IM_MAX       = 32'h13CC_CCCD;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 3'd0,
		CFG_IMAGE_HEIGHT = 3'd1,
		CFG_ITER_LIMIT   = 3'd2,
		CFG_RE_MIN       = 3'd3,
		CFG_RE_MAX       = 3'd4,
		CFG_IM_MIN       = 3'd5,
		CFG_IM_MAX       = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0]      image_width;
		logic [DIM_W-1:0]      image_height;
		logic [CNT_W-1:0]      iter_limit;
		logic [CFG_DATA_W-1:0] re_min;
		logic [CFG_DATA_W-1:0] re_max;
		logic [CFG_DATA_W-1:0] im_min;
		logic [CFG_DATA_W-1:0] im_max;
	} cfg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [CNT_W-1:0]   escape_count;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULX,
		ST_DIVX,
		ST_WAITX,
		ST_MULY,
		ST_DIVY,
		ST_WAITY,
		ST_SQR_RE,
		ST_SQR_IM,
		ST_CROSS,
		ST_UPDATE,
		ST_COLOR,
		ST_COL_WAIT,
		ST_DONE
	} state_t;

	// clamp to the signed coordinate range
	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [SAT_W-1:0] v
	);
		logic signed [SAT_W-1:0] back;
		back = SAT_W'($signed(v[COORD_BITS-1:0]));
		if (back == v) begin
			sat_coord = $signed(v[COORD_BITS-1:0]);
		end else if (v[SAT_W-1]) begin
			sat_coord = $signed({1'b1, {(COORD_BITS - 1){1'b0}}});
		end else begin
			sat_coord = $signed({1'b0, {(COORD_BITS - 1){1'b1}}});
		end
	endfunction

	// divisor for the coordinate mapping, never zero
	function automatic logic [DVS_W-1:0] map_divisor(input logic [DIM_W-1:0] dim);
		if (dim < DIM_W'(2)) begin
			map_divisor = DVS_W'(1);
		end else begin
			map_divisor = DVS_W'(dim - DIM_W'(1));
		end
	endfunction

endpackage

>>> hw/rtl/mep_mul.sv
// shared signed multiplier with registered product
// depends on mep_pkg
module mep_mul
	import mep_pkg::*;
(
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p
);

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

>>> hw/rtl/mep_div.sv
// shared unsigned restoring divider, one quotient bit per cycle
// depends on mep_pkg
module mep_div
	import mep_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quo_q[DVD_W-1]};
		diff     = trial - {1'b0, dvs_q};
		ge       = trial >= {1'b0, dvs_q};
		rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hw/rtl/mep_core.sv
// sequencer and datapath: coordinate mapping, escape iteration, colour
// depends on mep_pkg, mep_mul, mep_div
module mep_core
	import mep_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [PIX_W-1:0] px,
	input  logic [PIX_W-1:0] py,
	input  cfg_t             cfg,
	output logic             idle,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	state_t state_q, state_d;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     div_start;
	logic [DVD_W-1:0]         div_dividend;
	logic [DVS_W-1:0]         div_divisor;
	logic                     div_done;
	logic [DVD_W-1:0]         div_quot;

	logic [PIX_W-1:0]             px_q, py_q;
	logic                         neg_q;
	logic signed [COORD_BITS-1:0] cr_q, ci_q, zr_q, zi_q;
	logic signed [SQ_W-1:0]       zr2_q, zi2_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [COLOR_W-1:0]           red_q, green_q, blue_q;

	logic signed [MUL_W-1:0]   span_x, span_y;
	logic signed [DVD_W:0]     map_prod;
	logic [DVD_W:0]            map_abs;
	logic signed [DVD_W:0]     map_q;
	logic signed [SQ_W-1:0]    sq_now;
	logic signed [SQ_W:0]      mag_sum;
	logic                      escaped;
	logic signed [CROSS_W-1:0] cross_now;
	logic                      at_limit;
	logic [2*CNT_W-1:0]        col_dividend;
	logic [COLOR_W-1:0]        col;

	mep_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	mep_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		span_x       = MUL_W'($signed(cfg.re_max)) - MUL_W'($signed(cfg.re_min));
		span_y       = MUL_W'($signed(cfg.im_max)) - MUL_W'($signed(cfg.im_min));
		map_prod     = $signed(prod[DVD_W:0]);
		map_abs      = map_prod[DVD_W] ? (DVD_W + 1)'(-map_prod) : map_prod;
		map_q        = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
		sq_now       = $signed(prod[PROD_W-1:FRAC_BITS]);
		mag_sum      = (SQ_W + 1)'(zr2_q) + (SQ_W + 1)'(sq_now);
		escaped      = mag_sum > ESCAPE_LIMIT;
		cross_now    = $signed(prod[PROD_W-1:FRAC_BITS-1]);
		at_limit     = cnt_q == cfg.iter_limit;
		col_dividend = {cnt_q, {CNT_W{1'b0}}} - (2 * CNT_W)'(cnt_q);
		col          = div_quot[COLOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, multiplier operands and divider requests
	always_comb begin
		state_d      = state_q;
		mul_a        = MUL_W'(zr_q);
		mul_b        = MUL_W'(zr_q);
		div_start    = 1'b0;
		div_dividend = map_abs[DVD_W-1:0];
		div_divisor  = map_divisor(cfg.image_width);
		idle         = 1'b0;
		res_valid    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					state_d = ST_MULX;
				end
			end
			ST_MULX: begin
				mul_a   = span_x;
				mul_b   = $signed(MUL_W'(px_q));
				state_d = ST_DIVX;
			end
			ST_DIVX: begin
				div_start = 1'b1;
				state_d   = ST_WAITX;
			end
			ST_WAITX: begin
				if (div_done) begin
					state_d = ST_MULY;
				end
			end
			ST_MULY: begin
				mul_a   = span_y;
				mul_b   = $signed(MUL_W'(py_q));
				state_d = ST_DIVY;
			end
			ST_DIVY: begin
				div_start   = 1'b1;
				div_divisor = map_divisor(cfg.image_height);
				state_d     = ST_WAITY;
			end
			ST_WAITY: begin
				if (div_done) begin
					state_d = ST_SQR_RE;
				end
			end
			ST_SQR_RE: begin
				state_d = at_limit ? ST_COLOR : ST_SQR_IM;
			end
			ST_SQR_IM: begin
				mul_a   = MUL_W'(zi_q);
				mul_b   = MUL_W'(zi_q);
				state_d = ST_CROSS;
			end
			ST_CROSS: begin
				mul_a   = MUL_W'(zr_q);
				mul_b   = MUL_W'(zi_q);
				state_d = escaped ? ST_COLOR : ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_SQR_RE;
			end
			ST_COLOR: begin
				div_dividend = DVD_W'(col_dividend);
				div_divisor  = DVS_W'(cfg.iter_limit);
				if (at_limit) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_COL_WAIT;
				end
			end
			ST_COL_WAIT: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath registers, loaded by state
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					px_q <= px;
					py_q <= py;
				end
			end
			ST_DIVX, ST_DIVY: begin
				neg_q <= map_prod[DVD_W];
			end
			ST_WAITX: begin
				if (div_done) begin
					cr_q <= sat_coord(SAT_W'($signed(cfg.re_min)) + SAT_W'(map_q));
				end
			end
			ST_WAITY: begin
				if (div_done) begin
					ci_q  <= sat_coord(SAT_W'($signed(cfg.im_max)) - SAT_W'(map_q));
					zr_q  <= cr_q;
					zi_q  <= sat_coord(SAT_W'($signed(cfg.im_max)) - SAT_W'(map_q));
					cnt_q <= '0;
				end
			end
			ST_SQR_IM: begin
				zr2_q <= sq_now;
			end
			ST_CROSS: begin
				zi2_q <= sq_now;
			end
			ST_UPDATE: begin
				zi_q  <= sat_coord(SAT_W'(cross_now) + SAT_W'(ci_q));
				zr_q  <= sat_coord(SAT_W'(zr2_q) - SAT_W'(zi2_q) + SAT_W'(cr_q));
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_COLOR: begin
				if (at_limit) begin
					red_q   <= COLOR_NONE;
					green_q <= COLOR_NONE;
					blue_q  <= COLOR_NONE;
				end
			end
			ST_COL_WAIT: begin
				if (div_done) begin
					if (cnt_q > (cfg.iter_limit >> 1)) begin
						red_q   <= col;
						green_q <= COLOR_FULL;
						blue_q  <= COLOR_FULL;
					end else begin
						red_q   <= COLOR_NONE;
						green_q <= col;
						blue_q  <= col;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign res.red          = red_q;
	assign res.green        = green_q;
	assign res.blue         = blue_q;
	assign res.escape_count = cnt_q;

endmodule

>>> hw/rtl/mandelbrot_escape_pixel.sv
// mapping: per axis a multiply, then one 44-step pass of the shared divider and its wait
// state; each iteration then runs the real square, imaginary square, cross and update states
// on one shared multiplier; then color: a pixel that escapes gets a color division, one
// that never escapes skips it
// throughput: one item at a time, next item taken the cycle after the result moves to
// the output register; reset clears control state and loads defaults; needs mep_core
module mandelbrot_escape_pixel
	import mep_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// input item stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // pixel_x [11:0], pixel_y [23:12]
	// result item stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [79:0]           m_tdata,   // red, green, blue, alpha, escape_count
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic core_idle;
	logic core_res_valid;
	logic core_res_ready;
	res_t core_res;
	res_t out_q;
	logic out_valid_q;
	logic in_accept;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.iter_limit   <= RST_ITER_LIMIT;
			cfg_q.re_min       <= RST_RE_MIN;
			cfg_q.re_max       <= RST_RE_MAX;
			cfg_q.im_min       <= RST_IM_MIN;
			cfg_q.im_max       <= RST_IM_MAX;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[DIM_W-1:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[DIM_W-1:0];
				CFG_ITER_LIMIT:   cfg_q.iter_limit   <= cfg_data[CNT_W-1:0];
				CFG_RE_MIN:       cfg_q.re_min       <= cfg_data;
				CFG_RE_MAX:       cfg_q.re_max       <= cfg_data;
				CFG_IM_MIN:       cfg_q.im_min       <= cfg_data;
				CFG_IM_MAX:       cfg_q.im_max       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input side: the sequencer takes a new item whenever it is idle
	assign s_tready  = core_idle;
	assign in_accept = s_tvalid && core_idle;

	mep_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept),
		.px        (s_tdata[PIX_W-1:0]),
		.py        (s_tdata[2*PIX_W-1:PIX_W]),
		.cfg       (cfg_q),
		.idle      (core_idle),
		.res_valid (core_res_valid),
		.res_ready (core_res_ready),
		.res       (core_res)
	);

	// output register parts the sequencer from the result stream
	assign core_res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_valid && core_res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res_valid && core_res_ready) begin
			out_q <= core_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.escape_count, ALPHA_OPAQUE, out_q.blue, out_q.green, out_q.red};

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for mandelbrot_escape_pixel: a directed table, then random config phases
// results are checked against a fixed-point escape-time predictor kept in this file
// depends on mep_pkg and the mandelbrot_escape_pixel rtl
module tb_top;
	import mep_pkg::*;

	localparam int     CYCLE_LIMIT   = 10_000_000;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     PHASES        = 14;
	localparam int     PHASE_ITEMS   = 125;
	localparam longint Q_MAX         = 64'sd2147483647;
	localparam longint Q_MIN         = -64'sd2147483648;
	localparam longint ESCAPE_Q      = longint'(4) <<< FRAC_BITS;
	// index past the register list, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	// one result item, red in the top bits of the struct
	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] alpha;
		logic [CNT_W-1:0]   count;
	} pix_res_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	// one row of the directed table: a register write or a pixel item
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [PIX_W-1:0]      x;
		logic [PIX_W-1:0]      y;
		logic                  typed;
		pix_res_t              want;
	} stim_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;  // pixel_x [11:0], pixel_y [23:12]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [79:0]           m_tdata;         // red, green, blue, alpha, escape_count
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// bench copy of the register file, loaded with the reset values
	logic [DIM_W-1:0]             img_w    = RST_IMAGE_WIDTH;
	logic [DIM_W-1:0]             img_h    = RST_IMAGE_HEIGHT;
	logic [CNT_W-1:0]             iter_cap = RST_ITER_LIMIT;
	logic signed [COORD_BITS-1:0] re_lo    = RST_RE_MIN;
	logic signed [COORD_BITS-1:0] re_hi    = RST_RE_MAX;
	logic signed [COORD_BITS-1:0] im_lo    = RST_IM_MIN;
	logic signed [COORD_BITS-1:0] im_hi    = RST_IM_MAX;

	pix_res_t colors_due[$];  // expected colors in pixel order
	int       mismatches  = 0;
	int       cycle_count = 0;
	logic     quiet       = 1'b0;  // no idling on either side while set

	mandelbrot_escape_pixel i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint clamp_q(input longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	// pixel index to plane coordinate; tiny dimensions divide by one
	function automatic longint map_axis(input longint base, input longint span,
			input logic [PIX_W-1:0] pos, input logic [DIM_W-1:0] dim, input logic down);
		longint divisor;
		longint step_q;
		divisor = (dim < 2) ? 64'sd1 : longint'(dim) - 1;
		step_q  = (longint'(pos) * span) / divisor;  // truncates toward zero
		return clamp_q(down ? base - step_q : base + step_q);
	endfunction

	// escape count and color of one pixel under the current registers
	function automatic pix_res_t pixel_color(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		longint          cr, ci, zr, zi, zr2, zi2, zrzi;
		longint unsigned lim, n, shade;
		logic            escaped;
		pix_res_t        r;
		cr  = map_axis(re_lo, longint'(re_hi) - longint'(re_lo), x, img_w, 1'b0);
		ci  = map_axis(im_hi, longint'(im_hi) - longint'(im_lo), y, img_h, 1'b1);
		zr  = cr;
		zi  = ci;
		lim = 64'(iter_cap);
		n   = 0;
		escaped = 1'b0;
		while (!escaped && n < lim) begin
			// squares floor back to q4.28, the escape test sees them unsaturated
			zr2 = (zr * zr) >>> FRAC_BITS;
			zi2 = (zi * zi) >>> FRAC_BITS;
			if (zr2 + zi2 > ESCAPE_Q) begin
				escaped = 1'b1;
			end else begin
				zrzi = (zr * zi) >>> (FRAC_BITS - 1);
				zi = clamp_q(zrzi + ci);
				zr = clamp_q(zr2 - zi2 + cr);
				n++;
			end
		end
		r.alpha = ALPHA_OPAQUE;
		r.count = n[CNT_W-1:0];
		r.red   = COLOR_NONE;
		r.green = COLOR_NONE;
		r.blue  = COLOR_NONE;
		// points that never escape stay black
		if (n != lim) begin
			shade = (n * 65535) / lim;
			if (n > lim / 2) begin
				r.red   = shade[COLOR_W-1:0];
				r.green = COLOR_FULL;
				r.blue  = COLOR_FULL;
			end else begin
				r.green = shade[COLOR_W-1:0];
				r.blue  = shade[COLOR_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t row;
		row      = '0;
		row.kind = ROW_WRITE;
		row.idx  = idx;
		row.data = data;
		return row;
	endfunction

	function automatic stim_row_t pix_row(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
		stim_row_t row;
		row      = '0;
		row.kind = ROW_PIXEL;
		row.x    = x;
		row.y    = y;
		return row;
	endfunction

	// pixel whose result is known by eye: black with the given count
	function automatic stim_row_t black_row(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
			input logic [CNT_W-1:0] n);
		stim_row_t row;
		row       = pix_row(x, y);
		row.typed = 1'b1;
		row.want  = {COLOR_NONE, COLOR_NONE, COLOR_NONE, ALPHA_OPAQUE, n};
		return row;
	endfunction

	// one register write per clock; the caller drops the enable after a group
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_IMAGE_WIDTH:  img_w    = val[DIM_W-1:0];
			CFG_IMAGE_HEIGHT: img_h    = val[DIM_W-1:0];
			CFG_ITER_LIMIT:   iter_cap = val[CNT_W-1:0];
			CFG_RE_MIN:       re_lo    = val;
			CFG_RE_MAX:       re_hi    = val;
			CFG_IM_MIN:       im_lo    = val;
			CFG_IM_MAX:       im_hi    = val;
			default: ;
		endcase
	endtask

	// stop sending and wait until every pending pixel has come back
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (colors_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offer one pixel item, maybe after a gap, and record its color once taken
	task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
			input logic typed, input pix_res_t want);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		do @(posedge clk); while (!s_tready);
		colors_due.push_back(typed ? want : pixel_color(x, y));
	endtask

	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		end
	endtask

	// result side: check every taken item, stall in random bursts
	initial begin : result_side
		int       stall;
		pix_res_t got;
		pix_res_t want;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
					m_tdata[79:64]};
				if (colors_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with no pixel pending, expected none got %h",
						$time, m_tdata);
				end else begin
					want = colors_due.pop_front();
					check_field("red", want.red, got.red);
					check_field("green", want.green, got.green);
					check_field("blue", want.blue, got.blue);
					check_field("alpha", want.alpha, got.alpha);
					check_field("escape_count", want.count, got.count);
				end
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		stim_row_t        rows[$];
		stim_row_t        row;
		logic             writing;
		longint           c_re, c_im, half_re, half_im;
		longint           lo_re, hi_re, lo_im, hi_im;
		int unsigned      flavor, w, h, lim, x_top, y_top;
		logic [PIX_W-1:0] px, py;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window: the top left corner sits at -2 + 1.2375i and escapes at once
		rows.push_back(black_row(0, 0, 0));
		rows.push_back(pix_row(799, 649));
		rows.push_back(pix_row(400, 325));
		rows.push_back(pix_row(560, 325));
		// coordinates past the image edge are still mapped
		rows.push_back(pix_row(4095, 4095));
		rows.push_back(pix_row(4095, 0));
		rows.push_back(pix_row(0, 4095));
		// zero iteration limit: count equals the limit, so black
		rows.push_back(cfg_row(CFG_ITER_LIMIT, 0));
		rows.push_back(black_row(560, 325, 0));
		rows.push_back(cfg_row(CFG_ITER_LIMIT, 1));
		rows.push_back(pix_row(560, 325));
		rows.push_back(black_row(0, 0, 0));
		// image sizes below two act as two
		rows.push_back(cfg_row(CFG_IMAGE_WIDTH, 0));
		rows.push_back(cfg_row(CFG_IMAGE_HEIGHT, 1));
		rows.push_back(cfg_row(CFG_ITER_LIMIT, 30));
		rows.push_back(pix_row(1, 1));
		rows.push_back(pix_row(4095, 4095));
		rows.push_back(black_row(0, 0, 0));
		rows.push_back(cfg_row(CFG_IMAGE_WIDTH, 4096));
		rows.push_back(cfg_row(CFG_IMAGE_HEIGHT, 8191));
		rows.push_back(pix_row(4095, 4095));
		rows.push_back(pix_row(2048, 4000));
		// widest borders: every corner is far outside and escapes at count zero
		rows.push_back(cfg_row(CFG_RE_MIN, 32'h8000_0000));
		rows.push_back(cfg_row(CFG_RE_MAX, 32'h7FFF_FFFF));
		rows.push_back(cfg_row(CFG_IM_MIN, 32'h8000_0000));
		rows.push_back(cfg_row(CFG_IM_MAX, 32'h7FFF_FFFF));
		rows.push_back(cfg_row(CFG_IMAGE_WIDTH, 2));
		rows.push_back(cfg_row(CFG_IMAGE_HEIGHT, 2));
		rows.push_back(cfg_row(CFG_ITER_LIMIT, 16'hFFFF));
		rows.push_back(black_row(0, 0, 0));
		rows.push_back(black_row(1, 1, 0));
		rows.push_back(black_row(4095, 4095, 0));
		rows.push_back(black_row(4095, 0, 0));
		// collapsed window at the origin never escapes
		rows.push_back(cfg_row(CFG_RE_MIN, 0));
		rows.push_back(cfg_row(CFG_RE_MAX, 0));
		rows.push_back(cfg_row(CFG_IM_MIN, 0));
		rows.push_back(cfg_row(CFG_IM_MAX, 0));
		rows.push_back(cfg_row(CFG_ITER_LIMIT, 2000));
		rows.push_back(black_row(7, 3, 2000));
		// a write past the register list is dropped
		rows.push_back(cfg_row(CFG_ITER_LIMIT, 10));
		rows.push_back(cfg_row(CFG_UNUSED, 32'hDEAD_BEEF));
		rows.push_back(black_row(1, 2, 10));
		// mirrored window, borders given the wrong way round
		rows.push_back(cfg_row(CFG_RE_MIN, 32'h1000_0000));
		rows.push_back(cfg_row(CFG_RE_MAX, 32'hE000_0000));
		rows.push_back(cfg_row(CFG_IM_MIN, 32'h13CC_CCCD));
		rows.push_back(cfg_row(CFG_IM_MAX, 32'hECCC_CCCD));
		rows.push_back(cfg_row(CFG_IMAGE_WIDTH, 64));
		rows.push_back(cfg_row(CFG_IMAGE_HEIGHT, 48));
		rows.push_back(cfg_row(CFG_ITER_LIMIT, 64));
		rows.push_back(pix_row(10, 7));
		rows.push_back(pix_row(63, 47));
		rows.push_back(pix_row(31, 24));

		// walk the table; a group of writes only starts once the block is idle
		writing = 1'b0;
		foreach (rows[i]) begin
			row = rows[i];
			if (row.kind == ROW_WRITE) begin
				if (!writing) drain_block();
				writing = 1'b1;
				write_reg(row.idx, row.data);
			end else begin
				if (writing) cfg_wr_en <= 1'b0;
				writing = 1'b0;
				send_pixel(row.x, row.y, row.typed, row.want);
			end
		end

		// random phases: mostly windows around the set, some raw register noise
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_block();
			quiet  = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
			flavor = $urandom_range(0, 9);
			c_re    = longint'($urandom_range(0, 805306368)) - 590558003;
			c_im    = longint'($urandom_range(0, 697932185)) - 348966093;
			half_re = longint'($urandom_range(1 << 20, 1 << 29) >> $urandom_range(0, 6));
			half_im = longint'($urandom_range(1 << 20, 1 << 29) >> $urandom_range(0, 6));
			lo_re = c_re - half_re;
			hi_re = c_re + half_re;
			lo_im = c_im - half_im;
			hi_im = c_im + half_im;
			if ($urandom_range(0, 4) == 0) begin
				w = $urandom_range(2, 4096);
				h = $urandom_range(2, 4096);
			end else begin
				w = $urandom_range(2, 64);
				h = $urandom_range(2, 64);
			end
			lim = ($urandom_range(0, 4) == 0) ? $urandom_range(49, 160) : $urandom_range(1, 48);
			if (flavor == 7) begin
				// anything the register fields hold
				w     = $urandom_range(0, 8191);
				h     = $urandom_range(0, 8191);
				lim   = $urandom_range(1, 64);
				lo_re = longint'($urandom());
				hi_re = longint'($urandom());
				lo_im = longint'($urandom());
				hi_im = longint'($urandom());
			end else if (flavor == 8) begin
				// degenerate sizes and mirrored borders
				w = $urandom_range(0, 3);
				h = $urandom_range(0, 3);
				{lo_re, hi_re} = {hi_re, lo_re};
				{lo_im, hi_im} = {hi_im, lo_im};
			end
			write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
			write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
			write_reg(CFG_ITER_LIMIT, CFG_DATA_W'(lim));
			write_reg(CFG_RE_MIN, CFG_DATA_W'(lo_re));
			write_reg(CFG_RE_MAX, CFG_DATA_W'(hi_re));
			write_reg(CFG_IM_MIN, CFG_DATA_W'(lo_im));
			write_reg(CFG_IM_MAX, CFG_DATA_W'(hi_im));
			if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom());
			cfg_wr_en <= 1'b0;

			// most pixels inside the image, some anywhere in the 12-bit range
			x_top = (img_w < 2) ? 1 : ((img_w > 4096) ? 4095 : 32'(img_w) - 1);
			y_top = (img_h < 2) ? 1 : ((img_h > 4096) ? 4095 : 32'(img_h) - 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					px = PIX_W'($urandom_range(0, 4095));
					py = PIX_W'($urandom_range(0, 4095));
				end else begin
					px = PIX_W'($urandom_range(0, x_top));
					py = PIX_W'($urandom_range(0, y_top));
				end
				send_pixel(px, py, 1'b0, '0);
			end
		end

		drain_block();
		if (colors_due.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/mep_pkg.sv
hw/rtl/mep_mul.sv
hw/rtl/mep_div.sv
hw/rtl/mep_core.sv
hw/rtl/mandelbrot_escape_pixel.sv
tb/sv/tb_top.sv
